// ===== rtl/core/lpdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Length-prefix deframer queue: shared package
// Request and status codes, controller states and fixed field widths.
// ----------------------------------------------------------------------------
package lpdq_pkg;

  // Fixed widths of the request and result fields.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LIMIT_W   = 13;
  localparam int unsigned LEN_OUT_W = 13;
  localparam int unsigned QUEUED_W  = 4;
  localparam int unsigned STATUS_W  = 3;

  // Header length accumulator saturates at its full 14-bit range.
  localparam int unsigned ACCUM_W  = 14;
  localparam int unsigned PROD_W   = 18;
  localparam int unsigned ACCUM_MAX = 16383;
  localparam int unsigned DEC_BASE = 10;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;

  typedef enum logic {
    REQ_LINK = 1'b0,
    REQ_READ = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_STORED  = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_DROPPED = 3'd3,
    ST_TRUNC   = 3'd4
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

endpackage

// ===== rtl/core/length_prefix_deframer_queue.sv =====
// ----------------------------------------------------------------------------
// Length-prefix deframer queue
// Splits a link byte stream into ASCII-length-prefixed messages, queues them
// in a ring of message slots and hands them out one byte per read request.
// ----------------------------------------------------------------------------
// Each request runs through S_IDLE and S_EXEC: on acceptance the controller
// issues reads of the message memory and the slot-length memory, in S_EXEC
// it takes the registered read data, updates the queue state, writes back and
// loads the result register. A new request is accepted only in S_IDLE and
// while the result register is empty or its result is being taken in the
// same cycle, so the block takes no new request before the previous one has
// executed. Each message starts with HEADER_DIGITS header bytes whose leading
// ASCII decimal digits give its payload length; the first non-digit ends the
// number. Whether a message is kept is decided on the last header byte: if
// all SLOTS slots are occupied the message is dropped (its payload is still
// consumed from the link), and a length above MAX_MSG is stored truncated to
// MAX_MSG bytes and flagged. A read returns at most one byte of the oldest
// message and pops it once min(read_limit, length) bytes have gone out. The
// memories need no clearing after reset: only bytes inside a stored message
// are ever read back.
// ----------------------------------------------------------------------------
module length_prefix_deframer_queue #(
  parameter int unsigned SLOTS         = 8,
  parameter int unsigned MAX_MSG       = 4096,
  parameter int unsigned HEADER_DIGITS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [lpdq_pkg::BYTE_W-1:0]         link_byte_i,
  input  logic [lpdq_pkg::LIMIT_W-1:0]        read_limit_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lpdq_pkg::BYTE_W-1:0]         data_byte_o,
  output logic                                data_valid_o,
  output logic                                last_byte_o,
  output logic [lpdq_pkg::STATUS_W-1:0]       status_o,
  output logic [lpdq_pkg::QUEUED_W-1:0]       queued_messages_o,
  output logic [lpdq_pkg::LEN_OUT_W-1:0]      message_length_o
);

  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned OCC_W       = $clog2(SLOTS + 1);
  localparam int unsigned OFF_W       = $clog2(MAX_MSG);
  localparam int unsigned SL_W        = $clog2(MAX_MSG + 1);
  localparam int unsigned HI_W        = $clog2(HEADER_DIGITS + 1);
  localparam int unsigned STORE_DEPTH = SLOTS << OFF_W;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned AW_         = lpdq_pkg::ACCUM_W;

  localparam logic [AW_-1:0]    MAX_MSG_A = AW_'(MAX_MSG);
  localparam logic [OCC_W-1:0]  SLOTS_OCC = OCC_W'(SLOTS);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [HI_W-1:0]   HDR_LAST  = HI_W'(HEADER_DIGITS);

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  lpdq_pkg::state_e state_q, state_d;
  logic             in_accept;
  logic             exec;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpdq_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = lpdq_pkg::S_EXEC;
        end
      end
      lpdq_pkg::S_EXEC: state_d = lpdq_pkg::S_IDLE;
      default:          state_d = lpdq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    exec       = 1'b0;
    unique case (state_q)
      lpdq_pkg::S_IDLE: in_ready_o = !out_valid_q || out_ready_i;
      lpdq_pkg::S_EXEC: exec = 1'b1;
      default: begin
        in_ready_o = 1'b0;
        exec       = 1'b0;
      end
    endcase
  end

  assign in_accept = in_valid_i && in_ready_o;

  // Captured request, held while the memories answer.
  lpdq_pkg::req_e                req_q;
  logic [lpdq_pkg::BYTE_W-1:0]   byte_q;
  logic [lpdq_pkg::LIMIT_W-1:0]  limit_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q   <= lpdq_pkg::req_e'(req_type_i);
      byte_q  <= link_byte_i;
      limit_q <= read_limit_i;
    end
  end

  // --------------------------------------------------------------------------
  // Queue and deframer state
  // --------------------------------------------------------------------------
  logic [HI_W-1:0]   header_index_q, header_index_d;
  logic              in_payload_q, in_payload_d;
  logic [AW_-1:0]    length_accum_q, length_accum_d;
  logic              digits_ended_q, digits_ended_d;
  logic [AW_-1:0]    remaining_q, remaining_d;
  logic              dropping_q, dropping_d;
  logic [SLOT_W-1:0] write_slot_q, write_slot_d;
  logic [SLOT_W-1:0] read_slot_q, read_slot_d;
  logic [OCC_W-1:0]  occupancy_q, occupancy_d;
  logic [SL_W-1:0]   read_offset_q, read_offset_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= lpdq_pkg::S_IDLE;
      out_valid_q    <= 1'b0;
      header_index_q <= '0;
      in_payload_q   <= 1'b0;
      length_accum_q <= '0;
      digits_ended_q <= 1'b0;
      remaining_q    <= '0;
      dropping_q     <= 1'b0;
      write_slot_q   <= '0;
      read_slot_q    <= '0;
      occupancy_q    <= '0;
      read_offset_q  <= '0;
    end else begin
      state_q        <= state_d;
      out_valid_q    <= out_valid_d;
      header_index_q <= header_index_d;
      in_payload_q   <= in_payload_d;
      length_accum_q <= length_accum_d;
      digits_ended_q <= digits_ended_d;
      remaining_q    <= remaining_d;
      dropping_q     <= dropping_d;
      write_slot_q   <= write_slot_d;
      read_slot_q    <= read_slot_d;
      occupancy_q    <= occupancy_d;
      read_offset_q  <= read_offset_d;
    end
  end

  // --------------------------------------------------------------------------
  // Memories: message bytes, addressed by slot and offset, and slot lengths.
  // Reads are issued when a request is accepted; writes happen in the
  // execute cycle, so a read never overlaps a write of the same request.
  // --------------------------------------------------------------------------
  logic                        store_we;
  logic [ADDR_W-1:0]           store_waddr;
  logic [ADDR_W-1:0]           store_raddr;
  logic [lpdq_pkg::BYTE_W-1:0] store_rdata;
  logic                        len_we;
  logic [SL_W-1:0]             len_wdata;
  logic [SL_W-1:0]             len_rdata;

  logic [AW_-1:0] pay_off;
  assign pay_off     = length_accum_q - remaining_q;
  assign store_waddr = ADDR_W'({write_slot_q, pay_off[OFF_W-1:0]});
  assign store_raddr = ADDR_W'({read_slot_q, read_offset_q[OFF_W-1:0]});

  lpdq_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (lpdq_pkg::BYTE_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (byte_q),
    .re_i    (in_accept),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  lpdq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SL_W)
  ) u_lengths (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (write_slot_q),
    .wdata_i (len_wdata),
    .re_i    (in_accept),
    .raddr_i (read_slot_q),
    .rdata_o (len_rdata)
  );

  // --------------------------------------------------------------------------
  // Header parsing terms
  // --------------------------------------------------------------------------
  logic                             is_digit;
  logic [lpdq_pkg::PROD_W-1:0]      accum_prod;
  logic [AW_-1:0]                   hdr_accum;
  logic [HI_W-1:0]                  hdr_idx_inc;
  logic                             hdr_end;
  logic                             queue_full;
  logic [AW_-1:0]                   pay_rem_dec;
  logic [AW_-1:0]                   fin_accum;
  logic [AW_-1:0]                   fin_stored;

  assign is_digit = !digits_ended_q && (byte_q >= lpdq_pkg::ASCII_ZERO) &&
                    (byte_q <= lpdq_pkg::ASCII_NINE);
  assign accum_prod = lpdq_pkg::PROD_W'(length_accum_q) *
                      lpdq_pkg::PROD_W'(lpdq_pkg::DEC_BASE) +
                      lpdq_pkg::PROD_W'(byte_q - lpdq_pkg::ASCII_ZERO);
  // Saturate the accumulator rather than wrap on long digit strings.
  assign hdr_accum = !is_digit ? length_accum_q :
                     (accum_prod > lpdq_pkg::PROD_W'(lpdq_pkg::ACCUM_MAX)) ?
                     AW_'(lpdq_pkg::ACCUM_MAX) : accum_prod[AW_-1:0];
  assign hdr_idx_inc = header_index_q + HI_W'(1);
  assign hdr_end     = hdr_idx_inc >= HDR_LAST;
  assign queue_full  = occupancy_q >= SLOTS_OCC;
  assign pay_rem_dec = (remaining_q != '0) ? remaining_q - AW_'(1) : '0;

  // The length that closes a message: fresh from the header for zero-length
  // messages, otherwise the one latched when the header ended.
  assign fin_accum  = in_payload_q ? length_accum_q : hdr_accum;
  assign fin_stored = (fin_accum > MAX_MSG_A) ? MAX_MSG_A : fin_accum;
  assign len_wdata  = SL_W'(fin_stored);

  // --------------------------------------------------------------------------
  // Read terms
  // --------------------------------------------------------------------------
  logic [AW_-1:0]  rd_lim;
  logic [AW_-1:0]  rd_len;
  logic [AW_-1:0]  rd_count;
  logic            rd_take;
  logic [SL_W-1:0] rd_off_next;

  assign rd_lim      = (AW_'(limit_q) > MAX_MSG_A) ? MAX_MSG_A : AW_'(limit_q);
  assign rd_len      = AW_'(len_rdata);
  assign rd_count    = (rd_lim < rd_len) ? rd_lim : rd_len;
  assign rd_take     = AW_'(read_offset_q) < rd_count;
  assign rd_off_next = rd_take ? read_offset_q + SL_W'(1) : read_offset_q;

  // --------------------------------------------------------------------------
  // Execute: update the state and build the result.
  // --------------------------------------------------------------------------
  logic                             finish;
  logic                             fin_drop;
  logic [lpdq_pkg::BYTE_W-1:0]      r_byte;
  logic                             r_dvalid;
  logic                             r_last;
  lpdq_pkg::status_e                r_status;
  logic [lpdq_pkg::LEN_OUT_W-1:0]   r_mlen;

  always_comb begin
    header_index_d = header_index_q;
    in_payload_d   = in_payload_q;
    length_accum_d = length_accum_q;
    digits_ended_d = digits_ended_q;
    remaining_d    = remaining_q;
    dropping_d     = dropping_q;
    write_slot_d   = write_slot_q;
    read_slot_d    = read_slot_q;
    occupancy_d    = occupancy_q;
    read_offset_d  = read_offset_q;
    store_we       = 1'b0;
    len_we         = 1'b0;
    finish         = 1'b0;
    fin_drop       = 1'b0;
    r_byte         = '0;
    r_dvalid       = 1'b0;
    r_last         = 1'b0;
    r_status       = lpdq_pkg::ST_OK;
    r_mlen         = '0;

    if (exec) begin
      unique case (req_q)
        lpdq_pkg::REQ_LINK: begin
          if (!in_payload_q) begin
            length_accum_d = hdr_accum;
            digits_ended_d = digits_ended_q || !is_digit;
            header_index_d = hdr_idx_inc;
            if (hdr_end) begin
              header_index_d = '0;
              digits_ended_d = 1'b0;
              fin_drop       = queue_full;
              if (queue_full) begin
                r_status = lpdq_pkg::ST_DROPPED;
                r_mlen   = lpdq_pkg::LEN_OUT_W'(fin_stored);
              end
              if (hdr_accum == '0) begin
                finish = 1'b1;
              end else begin
                in_payload_d = 1'b1;
                remaining_d  = hdr_accum;
                dropping_d   = queue_full;
              end
            end
          end else begin
            store_we    = !dropping_q && (pay_off < MAX_MSG_A);
            remaining_d = pay_rem_dec;
            fin_drop    = dropping_q;
            finish      = (pay_rem_dec == '0);
          end

          if (finish) begin
            if (!fin_drop) begin
              len_we       = 1'b1;
              write_slot_d = (write_slot_q == SLOT_LAST) ? '0 : write_slot_q + SLOT_W'(1);
              occupancy_d  = occupancy_q + OCC_W'(1);
              r_status     = (fin_accum > MAX_MSG_A) ? lpdq_pkg::ST_TRUNC :
                                                       lpdq_pkg::ST_STORED;
              r_mlen       = lpdq_pkg::LEN_OUT_W'(fin_stored);
            end
            in_payload_d   = 1'b0;
            dropping_d     = 1'b0;
            length_accum_d = '0;
            remaining_d    = '0;
          end
        end

        lpdq_pkg::REQ_READ: begin
          if (occupancy_q == '0) begin
            r_status = lpdq_pkg::ST_EMPTY;
          end else begin
            r_mlen        = lpdq_pkg::LEN_OUT_W'(len_rdata);
            r_dvalid      = rd_take;
            r_byte        = rd_take ? store_rdata : '0;
            read_offset_d = rd_off_next;
            if (AW_'(rd_off_next) >= rd_count) begin
              r_last        = 1'b1;
              read_offset_d = '0;
              read_slot_d   = (read_slot_q == SLOT_LAST) ? '0 : read_slot_q + SLOT_W'(1);
              occupancy_d   = occupancy_q - OCC_W'(1);
            end
          end
        end

        default: begin
          r_status = lpdq_pkg::ST_OK;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [lpdq_pkg::BYTE_W-1:0]    data_byte_q;
  logic                           data_valid_q;
  logic                           last_byte_q;
  lpdq_pkg::status_e              status_q;
  logic [lpdq_pkg::QUEUED_W-1:0]  queued_q;
  logic [lpdq_pkg::LEN_OUT_W-1:0] mlen_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      data_byte_q  <= r_byte;
      data_valid_q <= r_dvalid;
      last_byte_q  <= r_last;
      status_q     <= r_status;
      queued_q     <= lpdq_pkg::QUEUED_W'(occupancy_d);
      mlen_q       <= r_mlen;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign data_byte_o       = data_byte_q;
  assign data_valid_o      = data_valid_q;
  assign last_byte_o       = last_byte_q;
  assign status_o          = status_q;
  assign queued_messages_o = queued_q;
  assign message_length_o  = mlen_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The result register must be free whenever a request executes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpdq_pkg::S_EXEC) |-> !out_valid_q)
    else $error("result register busy during execute");

  // The queue never holds more messages than there are slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy_q <= SLOTS_OCC)
    else $error("occupancy above slot count");

  // While payload bytes are consumed the header counter rests at zero and
  // the remaining count is nonzero and never exceeds the announced length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> (header_index_q == '0) && (remaining_q <= length_accum_q) &&
                     (remaining_q != '0))
    else $error("payload counters inconsistent");

  // A pop on read frees exactly one slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec && (req_q == lpdq_pkg::REQ_READ) && r_last) |=>
      (occupancy_q == $past(occupancy_q) - OCC_W'(1)))
    else $error("pop did not free a slot");

endmodule

// ===== rtl/core/lpdq_ram.sv =====
// ----------------------------------------------------------------------------
// Length-prefix deframer queue: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lpdq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
